/* rtl/cll_pkg.sv */
// ----------------------------------------------------------------------------
// cll_pkg: shared types and constants for the C-like lexer
// Token codes, scan modes, result record and character class helpers.
// ----------------------------------------------------------------------------
package cll_pkg;

  localparam int MAX_TEXT_CHARS = 8;
  localparam logic [63:0] TEXT_MASK = {64{1'b1}} >> (64 - 8 * MAX_TEXT_CHARS);
  localparam logic [5:0] TEXT_CAP = 6'(MAX_TEXT_CHARS);

  localparam logic [63:0] KW_FUNC   = 64'h0000_0000_636e_7566;
  localparam logic [63:0] KW_RETURN = 64'h0000_6e72_7574_6572;
  localparam logic [63:0] KW_IF     = 64'h0000_0000_0000_6669;
  localparam logic [63:0] KW_WHILE  = 64'h0000_0065_6c69_6877;
  localparam logic [63:0] TXT_EQ    = 64'h0000_0000_0000_3d3d;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_UNDER = 8'h5f;

  typedef enum logic [4:0] {
    TT_FUNC    = 5'd0,
    TT_RET     = 5'd1,
    TT_IF      = 5'd2,
    TT_LOOP    = 5'd3,
    TT_ID      = 5'd4,
    TT_NUM     = 5'd5,
    TT_OPAREN  = 5'd6,
    TT_CPAREN  = 5'd7,
    TT_OBRACE  = 5'd8,
    TT_CBRACE  = 5'd9,
    TT_SEP     = 5'd10,
    TT_SEMI    = 5'd11,
    TT_SET     = 5'd12,
    TT_PLUS    = 5'd13,
    TT_SUB     = 5'd14,
    TT_MUL     = 5'd15,
    TT_DIV     = 5'd16,
    TT_EQ      = 5'd17,
    TT_LT      = 5'd18,
    TT_GT      = 5'd19,
    TT_EOF     = 5'd20,
    TT_UNKNOWN = 5'd21
  } tok_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_NUM   = 8'b0000_0010,
    S_IDENT = 8'b0000_0100,
    S_SLASH = 8'b0000_1000,
    S_EQ    = 8'b0001_0000,
    S_LINE  = 8'b0010_0000,
    S_BLOCK = 8'b0100_0000,
    S_STAR  = 8'b1000_0000
  } mode_t;

  typedef struct packed {
    tok_t        token_type;
    logic [63:0] token_text;
    logic [5:0]  text_length;
    logic        text_truncated;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] n;
  } scan_out_t;

  typedef struct packed {
    logic [2:0] count;
    logic       space_ok;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {[8'd9:8'd13], 8'd32});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  endfunction

  function automatic tok_t punct_type(input logic [7:0] c);
    tok_t t;
    case (c)
      8'h28:   t = TT_OPAREN;
      8'h29:   t = TT_CPAREN;
      8'h7b:   t = TT_OBRACE;
      8'h7d:   t = TT_CBRACE;
      8'h2c:   t = TT_SEP;
      8'h3b:   t = TT_SEMI;
      8'h2b:   t = TT_PLUS;
      8'h2d:   t = TT_SUB;
      8'h2a:   t = TT_MUL;
      8'h3c:   t = TT_LT;
      8'h3e:   t = TT_GT;
      default: t = TT_UNKNOWN;
    endcase
    return t;
  endfunction

  function automatic res_t make_res(input tok_t t, input logic [63:0] txt,
                                    input logic [5:0] len);
    res_t r;
    r.token_type     = t;
    r.token_text     = txt & TEXT_MASK;
    r.text_length    = len;
    r.text_truncated = (len > TEXT_CAP);
    r.last           = 1'b0;
    return r;
  endfunction

  function automatic tok_t word_type(input logic [63:0] buf_v, input logic [5:0] cnt);
    tok_t t;
    if (cnt == 6'd4 && buf_v == KW_FUNC) begin
      t = TT_FUNC;
    end else if (cnt == 6'd6 && buf_v == KW_RETURN) begin
      t = TT_RET;
    end else if (cnt == 6'd2 && buf_v == KW_IF) begin
      t = TT_IF;
    end else if (cnt == 6'd5 && buf_v == KW_WHILE) begin
      t = TT_LOOP;
    end else begin
      t = TT_ID;
    end
    return t;
  endfunction

endpackage

/* rtl/cll_scan.sv */
// ----------------------------------------------------------------------------
// cll_scan: lexer scan state and per-byte step logic
// Holds mode, end flag and pending token text; yields up to two tokens.
// ----------------------------------------------------------------------------
module cll_scan import cll_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] ch,
  output scan_out_t  so
);

  mode_t       mode_r, mode_nxt;
  logic        end_r, end_nxt;
  logic [63:0] buf_r, buf_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  logic pend_v, sec_v, do_idle;
  res_t pend, sec;
  res_t flush_num, flush_word, tok_div, tok_assign;
  logic [63:0] add_buf;
  logic [5:0]  add_cnt;

  always_comb begin
    flush_num  = make_res(TT_NUM, buf_r, cnt_r);
    flush_word = make_res(word_type(buf_r, cnt_r), buf_r, cnt_r);
    tok_div    = make_res(TT_DIV, {56'd0, CH_SLASH}, 6'd1);
    tok_assign = make_res(TT_SET, {56'd0, CH_EQUAL}, 6'd1);
    add_buf    = buf_r;
    if (cnt_r < 6'd8) begin
      add_buf[{cnt_r[2:0], 3'b000} +: 8] = ch;
    end
    add_cnt = (cnt_r < 6'd63) ? cnt_r + 6'd1 : cnt_r;
  end

  always_comb begin
    mode_nxt = mode_r;
    end_nxt  = end_r;
    buf_nxt  = buf_r;
    cnt_nxt  = cnt_r;
    pend_v   = 1'b0;
    sec_v    = 1'b0;
    pend     = flush_num;
    sec      = make_res(TT_EOF, 64'd0, 6'd0);
    do_idle  = 1'b0;
    if (end_r) begin
      mode_nxt = mode_r;
    end else if (ch == CH_NUL) begin
      sec_v    = 1'b1;
      mode_nxt = S_IDLE;
      end_nxt  = 1'b1;
      case (mode_r)
        S_NUM:   begin pend_v = 1'b1; pend = flush_num;  end
        S_IDENT: begin pend_v = 1'b1; pend = flush_word; end
        S_SLASH: begin pend_v = 1'b1; pend = tok_div;    end
        S_EQ:    begin pend_v = 1'b1; pend = tok_assign; end
        default: pend_v = 1'b0;
      endcase
    end else begin
      case (mode_r)
        S_NUM: begin
          if (is_digit(ch)) begin
            buf_nxt = add_buf;
            cnt_nxt = add_cnt;
          end else begin
            pend_v  = 1'b1;
            pend    = flush_num;
            do_idle = 1'b1;
          end
        end
        S_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
            buf_nxt = add_buf;
            cnt_nxt = add_cnt;
          end else begin
            pend_v  = 1'b1;
            pend    = flush_word;
            do_idle = 1'b1;
          end
        end
        S_SLASH: begin
          if (ch == CH_SLASH) begin
            mode_nxt = S_LINE;
          end else if (ch == CH_STAR) begin
            mode_nxt = S_BLOCK;
          end else begin
            pend_v  = 1'b1;
            pend    = tok_div;
            do_idle = 1'b1;
          end
        end
        S_EQ: begin
          pend_v = 1'b1;
          if (ch == CH_EQUAL) begin
            pend     = make_res(TT_EQ, TXT_EQ, 6'd2);
            mode_nxt = S_IDLE;
          end else begin
            pend    = tok_assign;
            do_idle = 1'b1;
          end
        end
        S_LINE: begin
          if (ch == CH_LF) mode_nxt = S_IDLE;
        end
        S_BLOCK: begin
          if (ch == CH_STAR) mode_nxt = S_STAR;
        end
        S_STAR: begin
          if (ch == CH_SLASH) begin
            mode_nxt = S_IDLE;
          end else if (ch != CH_STAR) begin
            mode_nxt = S_BLOCK;
          end
        end
        default: do_idle = 1'b1;
      endcase
      if (do_idle) begin
        mode_nxt = S_IDLE;
        if (is_space(ch)) begin
          mode_nxt = S_IDLE;
        end else if (is_digit(ch)) begin
          buf_nxt  = {56'd0, ch};
          cnt_nxt  = 6'd1;
          mode_nxt = S_NUM;
        end else if (is_alpha(ch) || ch == CH_UNDER) begin
          buf_nxt  = {56'd0, ch};
          cnt_nxt  = 6'd1;
          mode_nxt = S_IDENT;
        end else if (ch == CH_SLASH) begin
          mode_nxt = S_SLASH;
        end else if (ch == CH_EQUAL) begin
          mode_nxt = S_EQ;
        end else begin
          sec_v = 1'b1;
          sec   = make_res(punct_type(ch), {56'd0, ch}, 6'd1);
        end
      end
    end
  end

  // pack emitted tokens in order, flag the final one
  always_comb begin
    so.n  = {1'b0, pend_v} + {1'b0, sec_v};
    so.r0 = pend_v ? pend : sec;
    so.r1 = sec;
    so.r0.last = !(pend_v && sec_v);
    so.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= S_IDLE;
      end_r  <= 1'b0;
      buf_r  <= 64'd0;
      cnt_r  <= 6'd0;
    end else if (step) begin
      mode_r <= mode_nxt;
      end_r  <= end_nxt;
      buf_r  <= buf_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

/* rtl/cll_outq.sv */
// ----------------------------------------------------------------------------
// cll_outq: token result queue
// Four-entry queue taking up to two tokens per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module cll_outq import cll_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  scan_out_t so,
  input  logic      pop,
  output res_t      head,
  output q_stat_t   stat
);

  res_t       mem [4];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] n_in;
  logic [1:0] wp_p1;

  assign n_in  = push ? so.n : 2'd0;
  assign wp_p1 = wp_r + 2'd1;

  always_comb begin
    wp_nxt  = wp_r + n_in;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, n_in} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) begin
      mem[wp_r] <= so.r0;
    end
    if (n_in == 2'd2) begin
      mem[wp_p1] <= so.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head          = mem[rp_r];
  assign stat.count    = cnt_r;
  assign stat.space_ok = (cnt_r <= 3'd2);

endmodule

/* rtl/c_like_lexer.sv */
// ----------------------------------------------------------------------------
// c_like_lexer: streaming tokenizer for a small C-like language
// Bytes in, tokens out; comments and whitespace skipped, zero byte ends input.
//
//   channel   ports                                   dir  width
//   source    in_valid/in_ready/in_ch                 in   8
//   tokens    out_valid/out_ready/out_token_type,     out  5+64+6+1+1
//             out_token_text/out_text_length/
//             out_text_truncated/out_last
//
// One byte per cycle: byte register, one scan step, four-entry token queue.
// An accepted byte is registered, then scanned, and its tokens are written to the queue.
// A byte that yields two tokens holds two queue slots; scanning stalls when the
// queue has fewer than two free slots, and input stalls while a byte waits.
// Synchronous active-low reset clears the scan state and empties the queue.
// ----------------------------------------------------------------------------
module c_like_lexer import cll_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_type,
  output logic [63:0] out_token_text,
  output logic [5:0]  out_text_length,
  output logic        out_text_truncated,
  output logic        out_last
);

  logic       in_vld_r, in_vld_nxt;
  logic [7:0] ch_r;
  logic       step, in_acc, pop;
  scan_out_t  so;
  res_t       head;
  q_stat_t    stat;

  assign step     = in_vld_r && stat.space_ok;
  assign in_ready = !in_vld_r || stat.space_ok;
  assign in_acc   = in_valid && in_ready;
  assign pop      = out_valid && out_ready;

  always_comb begin
    in_vld_nxt = in_acc || (in_vld_r && !step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) ch_r <= in_ch;
  end

  cll_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .ch    (ch_r),
    .so    (so)
  );

  cll_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (step),
    .so    (so),
    .pop   (pop),
    .head  (head),
    .stat  (stat)
  );

  assign out_valid          = (stat.count != 3'd0);
  assign out_token_type     = head.token_type;
  assign out_token_text     = head.token_text;
  assign out_text_length    = head.text_length;
  assign out_text_truncated = head.text_truncated;
  assign out_last           = head.last;

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.count <= 3'd4)
    else $error("token queue overflow");

  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_token_type == TT_EOF) |-> out_last)
    else $error("eof token not marked last");

  a_q_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!step && !pop) |=> (stat.count == $past(stat.count)))
    else $error("queue count moved without request");

  a_q_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (step && so.n == 2'd2 && !pop) |=> (stat.count == $past(stat.count) + 3'd2))
    else $error("two-token step lost a request");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the c_like_lexer token scanner
// Feeds one source stream (short directed table, then random token-shaped
// text with noise and broken comments, a closing zero byte and ignored bytes
// after it), predicts every token in the testbench and checks each request
// on the token channel in order. Sender bursts and receiver stalls are random.
// ----------------------------------------------------------------------------
module tb_top;
  import cll_pkg::*;

  localparam int RAND_ITEMS   = 1300;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 2000;
  localparam int MAX_SHOWN    = 10;
  localparam logic [5:0] BUF_CHARS = 6'd8;
  localparam logic [5:0] LEN_SAT   = 6'd63;

  typedef enum int {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_BURSTY} rx_pat_t;

  typedef struct {
    logic [7:0] ch;
    bit         typed;
    res_t       want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_ch = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [4:0]  out_token_type;
  logic [63:0] out_token_text;
  logic [5:0]  out_text_length;
  logic        out_text_truncated;
  logic        out_last;

  c_like_lexer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_ch             (in_ch),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_token_type    (out_token_type),
    .out_token_text    (out_token_text),
    .out_text_length   (out_text_length),
    .out_text_truncated(out_text_truncated),
    .out_last          (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scanner shadow state
  mode_t       lx_mode = S_IDLE;
  logic        lx_done = 1'b0;
  logic [63:0] lx_text = '0;
  logic [5:0]  lx_len = '0;
  res_t        step_res [2];
  int          step_n;

  res_t        tokens_due [$];
  stim_row_t   stim_rows [$];
  logic [7:0]  seg_q [$];
  int          bad_count = 0;
  int          burst_left = 0;
  int          stall_cycles = 0;

  function automatic logic ws_char(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic digit_char(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic letter_char(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic tok_t single_type(logic [7:0] c);
    case (c)
      "(":     return TT_OPAREN;
      ")":     return TT_CPAREN;
      "{":     return TT_OBRACE;
      "}":     return TT_CBRACE;
      ",":     return TT_SEP;
      ";":     return TT_SEMI;
      "+":     return TT_PLUS;
      "-":     return TT_SUB;
      "*":     return TT_MUL;
      "<":     return TT_LT;
      ">":     return TT_GT;
      default: return TT_UNKNOWN;
    endcase
  endfunction

  function automatic void put_token(tok_t t, logic [63:0] txt, logic [5:0] len);
    if (step_n < 2) begin
      step_res[step_n].token_type     = t;
      step_res[step_n].token_text     = txt & TEXT_MASK;
      step_res[step_n].text_length    = len;
      step_res[step_n].text_truncated = (int'(len) > MAX_TEXT_CHARS);
      step_res[step_n].last           = 1'b0;
      step_n++;
    end
  endfunction

  function automatic tok_t word_kind();
    if (lx_len == 6'd4 && lx_text == KW_FUNC) return TT_FUNC;
    if (lx_len == 6'd6 && lx_text == KW_RETURN) return TT_RET;
    if (lx_len == 6'd2 && lx_text == KW_IF) return TT_IF;
    if (lx_len == 6'd5 && lx_text == KW_WHILE) return TT_LOOP;
    return TT_ID;
  endfunction

  function automatic void grow_text(logic [7:0] c);
    if (lx_len < BUF_CHARS) lx_text = lx_text | (64'(c) << (8 * int'(lx_len)));
    if (lx_len < LEN_SAT) lx_len = lx_len + 6'd1;
  endfunction

  function automatic void lex_idle(logic [7:0] c);
    lx_mode = S_IDLE;
    if (ws_char(c)) begin
    end else if (digit_char(c)) begin
      lx_text = 64'(c);
      lx_len  = 6'd1;
      lx_mode = S_NUM;
    end else if (letter_char(c) || c == CH_UNDER) begin
      lx_text = 64'(c);
      lx_len  = 6'd1;
      lx_mode = S_IDENT;
    end else if (c == CH_SLASH) begin
      lx_mode = S_SLASH;
    end else if (c == CH_EQUAL) begin
      lx_mode = S_EQ;
    end else begin
      put_token(single_type(c), 64'(c), 6'd1);
    end
  endfunction

  // one source byte through the shadow scanner; tokens land in step_res
  function automatic void lex_byte(logic [7:0] c);
    step_n = 0;
    if (!lx_done) begin
      if (c == CH_NUL) begin
        case (lx_mode)
          S_NUM:   put_token(TT_NUM, lx_text, lx_len);
          S_IDENT: put_token(word_kind(), lx_text, lx_len);
          S_SLASH: put_token(TT_DIV, 64'(CH_SLASH), 6'd1);
          S_EQ:    put_token(TT_SET, 64'(CH_EQUAL), 6'd1);
          default: ;
        endcase
        put_token(TT_EOF, '0, '0);
        lx_mode = S_IDLE;
        lx_done = 1'b1;
      end else begin
        case (lx_mode)
          S_NUM: begin
            if (digit_char(c)) begin
              grow_text(c);
            end else begin
              put_token(TT_NUM, lx_text, lx_len);
              lex_idle(c);
            end
          end
          S_IDENT: begin
            if (letter_char(c) || digit_char(c) || c == CH_UNDER) begin
              grow_text(c);
            end else begin
              put_token(word_kind(), lx_text, lx_len);
              lex_idle(c);
            end
          end
          S_SLASH: begin
            if (c == CH_SLASH) begin
              lx_mode = S_LINE;
            end else if (c == CH_STAR) begin
              lx_mode = S_BLOCK;
            end else begin
              put_token(TT_DIV, 64'(CH_SLASH), 6'd1);
              lex_idle(c);
            end
          end
          S_EQ: begin
            if (c == CH_EQUAL) begin
              put_token(TT_EQ, TXT_EQ, 6'd2);
              lx_mode = S_IDLE;
            end else begin
              put_token(TT_SET, 64'(CH_EQUAL), 6'd1);
              lex_idle(c);
            end
          end
          S_LINE: begin
            if (c == CH_LF) lx_mode = S_IDLE;
          end
          S_BLOCK: begin
            if (c == CH_STAR) lx_mode = S_STAR;
          end
          S_STAR: begin
            if (c == CH_SLASH) lx_mode = S_IDLE;
            else if (c != CH_STAR) lx_mode = S_BLOCK;
          end
          default: lex_idle(c);
        endcase
      end
      if (step_n > 0) step_res[step_n-1].last = 1'b1;
    end
  endfunction

  function automatic logic [7:0] word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return CH_UNDER;
    return 8'h30 + 8'(r - 53);
  endfunction

  // one chunk of source text: mostly well-formed tokens, some noise
  function automatic void make_segment();
    string kw [4] = '{"func", "return", "if", "while"};
    string punct = "(){},;+-*<>=/";
    string s;
    int kind, n, r;
    seg_q.delete();
    kind = $urandom_range(0, 99);
    r = $urandom_range(0, 99);
    n = (r < 75) ? $urandom_range(1, 8) : (r < 97) ? $urandom_range(9, 20)
                                                   : $urandom_range(60, 70);
    if (kind < 25) begin
      seg_q.push_back(word_char(1'b1));
      repeat (n - 1) seg_q.push_back(word_char(1'b0));
    end else if (kind < 37) begin
      s = kw[$urandom_range(0, 3)];
      r = $urandom_range(0, 9);
      for (int i = 0; i < ((r == 0) ? s.len() - 1 : s.len()); i++) seg_q.push_back(s[i]);
      if (r == 1) seg_q.push_back(word_char(1'b0));
    end else if (kind < 52) begin
      repeat (n) seg_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
    end else if (kind < 72) begin
      r = $urandom_range(0, punct.len());
      if (r == punct.len()) begin
        seg_q.push_back(CH_EQUAL);
        seg_q.push_back(CH_EQUAL);
      end else begin
        seg_q.push_back(punct[r]);
      end
    end else if (kind < 82) begin
      repeat ($urandom_range(1, 3)) begin
        r = $urandom_range(9, 14);
        seg_q.push_back((r == 14) ? 8'd32 : 8'(r));
      end
    end else if (kind < 87) begin
      seg_q.push_back(CH_SLASH);
      seg_q.push_back(CH_SLASH);
      repeat ($urandom_range(0, 12)) begin
        r = $urandom_range(1, 255);
        seg_q.push_back((8'(r) == CH_LF) ? "x" : 8'(r));
      end
      if ($urandom_range(0, 9) != 0) seg_q.push_back(CH_LF);
    end else if (kind < 92) begin
      seg_q.push_back(CH_SLASH);
      seg_q.push_back(CH_STAR);
      repeat ($urandom_range(0, 12)) begin
        seg_q.push_back(($urandom_range(0, 3) == 0) ? CH_STAR : 8'($urandom_range(1, 255)));
      end
      if ($urandom_range(0, 9) != 0) begin
        seg_q.push_back(CH_STAR);
        seg_q.push_back(CH_SLASH);
      end
    end else begin
      seg_q.push_back(8'($urandom_range(1, 255)));
    end
    if (kind < 52 && $urandom_range(0, 4) != 0) begin
      seg_q.push_back(($urandom_range(0, 1) == 0) ? 8'd32
                                                  : punct[$urandom_range(0, punct.len() - 1)]);
    end
  endfunction

  function automatic void add_plain(string s);
    stim_row_t row;
    row.typed = 1'b0;
    row.want  = '0;
    for (int i = 0; i < s.len(); i++) begin
      row.ch = s[i];
      stim_rows.push_back(row);
    end
  endfunction

  function automatic void add_typed(logic [7:0] c, tok_t t, logic [63:0] txt,
                                    logic [5:0] len);
    stim_row_t row;
    row.ch                  = c;
    row.typed               = 1'b1;
    row.want.token_type     = t;
    row.want.token_text     = txt;
    row.want.text_length    = len;
    row.want.text_truncated = 1'b0;
    row.want.last           = 1'b1;
    stim_rows.push_back(row);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input res_t want);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_ch    <= b;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    lex_byte(b);
    if (typed) begin
      tokens_due.push_back(want);
    end else begin
      for (int i = 0; i < step_n; i++) tokens_due.push_back(step_res[i]);
    end
  endtask

  initial begin
    string tail;
    int sent;
    add_typed(8'hff, TT_UNKNOWN, 64'hff, 6'd1);
    add_typed(8'h80, TT_UNKNOWN, 64'h80, 6'd1);
    add_typed(8'h01, TT_UNKNOWN, 64'h01, 6'd1);
    add_typed("(", TT_OPAREN, 64'h28, 6'd1);
    add_plain("if =");
    add_typed(CH_EQUAL, TT_EQ, TXT_EQ, 6'd2);
    add_plain("=+/*/x*/12;/ \t");

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) send_byte(stim_rows[i].ch, stim_rows[i].typed, stim_rows[i].want);

    sent = 0;
    while (sent < RAND_ITEMS) begin
      make_segment();
      foreach (seg_q[i]) send_byte(seg_q[i], 1'b0, '0);
      sent += seg_q.size();
    end

    // pending word flushed by the zero byte, then bytes that must be ignored
    tail = " end_9";
    for (int i = 0; i < tail.len(); i++) send_byte(tail[i], 1'b0, '0);
    send_byte(CH_NUL, 1'b0, '0);
    tail = "a(=";
    for (int i = 0; i < tail.len(); i++) send_byte(tail[i], 1'b0, '0);
    send_byte(8'hff, 1'b0, '0);
    send_byte(CH_NUL, 1'b0, '0);
    in_valid <= 1'b0;

    while (tokens_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (bad_count == 0 && tokens_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // receiver stall pattern
  rx_pat_t rx_mode = RX_FREE;
  int      rx_span = 0;
  int      rx_hold = 0;

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = rx_pat_t'($urandom_range(0, 3));
      rx_span = $urandom_range(32, 256);
    end else begin
      rx_span--;
    end
    case (rx_mode)
      RX_FREE:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 9) < 7);
      RX_SPARSE: out_ready <= ($urandom_range(0, 9) < 3);
      default: begin
        if (rx_hold > 0) begin
          rx_hold--;
          out_ready <= 1'b0;
        end else if ($urandom_range(0, 19) == 0) begin
          rx_hold = $urandom_range(5, 40);
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    endcase
  end

  // token checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (tokens_due.size() == 0) begin
        bad_count++;
        if (bad_count <= MAX_SHOWN) begin
          $display("unexpected token: type %0d text %h len %0d trunc %b last %b",
                   out_token_type, out_token_text, out_text_length,
                   out_text_truncated, out_last);
        end
      end else begin
        want = tokens_due.pop_front();
        if (out_token_type !== want.token_type || out_token_text !== want.token_text ||
            out_text_length !== want.text_length ||
            out_text_truncated !== want.text_truncated || out_last !== want.last) begin
          bad_count++;
          if (bad_count <= MAX_SHOWN) begin
            $display("token mismatch: exp type %0d text %h len %0d trunc %b last %b",
                     want.token_type, want.token_text, want.text_length,
                     want.text_truncated, want.last);
            $display("                got type %0d text %h len %0d trunc %b last %b",
                     out_token_type, out_token_text, out_text_length,
                     out_text_truncated, out_last);
          end
        end
      end
    end
  end

  // watchdog: no request moving on either side for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= IDLE_LIMIT) begin
        $display("timeout: no request moved in %0d cycles", IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
